/* hw/rtl/ehms_pkg.sv */
// Shared types and constants for the elapsed h:m:s timer with work and break alarms.
// No dependencies; imported by every module of the block.
package ehms_pkg;

    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
    localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
    localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(23);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 6;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WORK_HOURS   = 3'd0,
        CFG_WORK_MINUTES = 3'd1,
        CFG_WORK_SECONDS = 3'd2,
        CFG_REST_HOURS   = 3'd3,
        CFG_REST_MINUTES = 3'd4,
        CFG_REST_SECONDS = 3'd5
    } ehms_cfg_addr_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
    } ehms_time_t;

    typedef struct packed {
        ehms_time_t work;
        ehms_time_t rest;
    } ehms_targets_t;

    typedef struct packed {
        logic       beep_pulse;
        logic       rest_finished;
        logic       work_finished;
        ehms_time_t elapsed;
    } ehms_result_t;

endpackage

/* hw/rtl/ehms_cfg_regs.sv */
// Target registers for the work and break periods, written through a plain write port.
// Depends on ehms_pkg.
module ehms_cfg_regs
    import ehms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output ehms_targets_t         targets
);

    ehms_targets_t targets_reg;
    ehms_targets_t targets_next;

    always_comb begin
        targets_next = targets_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_WORK_HOURS:   targets_next.work.hours   = cfg_wdata[HOUR_W-1:0];
                CFG_WORK_MINUTES: targets_next.work.minutes = cfg_wdata[MIN_W-1:0];
                CFG_WORK_SECONDS: targets_next.work.seconds = cfg_wdata[SEC_W-1:0];
                CFG_REST_HOURS:   targets_next.rest.hours   = cfg_wdata[HOUR_W-1:0];
                CFG_REST_MINUTES: targets_next.rest.minutes = cfg_wdata[MIN_W-1:0];
                CFG_REST_SECONDS: targets_next.rest.seconds = cfg_wdata[SEC_W-1:0];
                default:          targets_next = targets_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            targets_reg.work.hours   <= '0;
            targets_reg.work.minutes <= '0;
            targets_reg.work.seconds <= SEC_W'(10);
            targets_reg.rest.hours   <= '0;
            targets_reg.rest.minutes <= '0;
            targets_reg.rest.seconds <= SEC_W'(10);
        end else begin
            targets_reg <= targets_next;
        end
    end

    assign targets = targets_reg;

endmodule

/* hw/rtl/ehms_core.sv */
// Elapsed counter, RTC edge detect, alarm compares and sticky flags; one transaction a cycle while in_accept is high.
// Depends on ehms_pkg.
module ehms_core
    import ehms_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic             in_clear,
    input  logic [SEC_W-1:0] in_rtc_second,
    input  logic             in_counting,
    input  ehms_targets_t    targets,
    output ehms_result_t     result
);

    ehms_time_t       count_reg, count_next;
    logic [SEC_W-1:0] last_rtc_reg, last_rtc_next;
    logic             work_done_reg, work_done_next;
    logic             rest_done_reg, rest_done_next;

    ehms_time_t stepped;
    ehms_time_t advanced_time;
    logic       advance;
    logic       work_hit;
    logic       rest_hit;
    logic       beep;

    // one-second increment with 60/60/24 wrap
    always_comb begin
        stepped = count_reg;
        if (count_reg.seconds == SEC_LAST) begin
            stepped.seconds = '0;
            if (count_reg.minutes == MIN_LAST) begin
                stepped.minutes = '0;
                stepped.hours   = (count_reg.hours == HOUR_LAST) ? '0
                                  : count_reg.hours + HOUR_W'(1);
            end else begin
                stepped.minutes = count_reg.minutes + MIN_W'(1);
            end
        end else begin
            stepped.seconds = count_reg.seconds + SEC_W'(1);
        end
    end

    always_comb begin
        advance        = !in_clear && in_counting && (in_rtc_second != last_rtc_reg);
        last_rtc_next  = in_clear ? last_rtc_reg : in_rtc_second;
        if (in_clear) begin
            advanced_time = '0;
        end else if (advance) begin
            advanced_time = stepped;
        end else begin
            advanced_time = count_reg;
        end

        work_hit = !work_done_reg && (advanced_time == targets.work);
        rest_hit = work_done_reg && (advanced_time == targets.rest);

        count_next     = work_hit ? '0 : advanced_time;
        work_done_next = work_done_reg | work_hit;
        rest_done_next = rest_done_reg | rest_hit;
        beep           = work_hit | (rest_hit & advance);

        result.elapsed       = count_next;
        result.work_finished = work_done_next;
        result.rest_finished = rest_done_next;
        result.beep_pulse    = beep;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            last_rtc_reg  <= '0;
            work_done_reg <= 1'b0;
            rest_done_reg <= 1'b0;
        end else if (in_accept) begin
            count_reg     <= count_next;
            last_rtc_reg  <= last_rtc_next;
            work_done_reg <= work_done_next;
            rest_done_reg <= rest_done_next;
        end
    end

endmodule

/* hw/rtl/ehms_out_buf.sv */
// Two-entry output register with skid stage; ready depends only on the skid entry.
// Depends on ehms_pkg.
module ehms_out_buf
    import ehms_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  ehms_result_t push_data,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output ehms_result_t out_data
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    ehms_result_t main_reg, main_next;
    ehms_result_t skid_reg, skid_next;
    logic         pop;

    always_comb begin
        pop             = main_valid_reg && out_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // drain the skid entry into the output register
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

/* hw/rtl/elapsed_hms_timer_with_alarms.sv */
// Elapsed h:m:s timer with work and break alarms, top level.
// A result is written to the output register, or to the skid entry while the output is stalled.
// Throughput: one transaction per cycle while s_tready is high; the counter update and compare are combinational.
// Two result entries absorb a stalled sink before s_tready drops.
// Reset (aresetn, synchronous, active low): counter, flags and buffers clear; targets
// return to 0:00:10 for both periods. Depends on ehms_pkg and its submodules.
module elapsed_hms_timer_with_alarms
    import ehms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [5:0] rtc_second, [6] counting, [7] zero
    input  logic                  s_tuser,   // [0] action (0 sample, 1 clear)
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [4:0] elapsed_hours, [10:5] elapsed_minutes,
                                             // [16:11] elapsed_seconds, [17] work_finished,
                                             // [18] rest_finished, [19] beep_pulse, [23:20] zero
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ehms_targets_t targets;
    ehms_result_t  result;
    ehms_result_t  out_data;
    logic          in_accept;
    logic          buf_space;

    // accept whenever the skid entry is free
    assign s_tready  = buf_space;
    assign in_accept = s_tvalid && buf_space;

    ehms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .targets   (targets)
    );

    ehms_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .in_clear      (s_tuser),
        .in_rtc_second (s_tdata[SEC_W-1:0]),
        .in_counting   (s_tdata[SEC_W]),
        .targets       (targets),
        .result        (result)
    );

    ehms_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data (result),
        .space     (buf_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // pack fields, hours in the lowest bits
    assign m_tdata = {4'b0000,
                      out_data.beep_pulse,
                      out_data.rest_finished,
                      out_data.work_finished,
                      out_data.elapsed.seconds,
                      out_data.elapsed.minutes,
                      out_data.elapsed.hours};

endmodule
